// File: hw/rtl/tcr_pkg.sv
package tcr_pkg;

  localparam int unsigned MAX_WIDTH_DEF  = 256;
  localparam int unsigned MAX_HEIGHT_DEF = 256;

  localparam int unsigned VIN_W      = 19;  // signed Q3.16 vertex coordinate
  localparam int unsigned Q_FRAC     = 16;
  localparam int unsigned SIZE_W     = 9;   // width and height registers
  localparam int unsigned STEP_W     = 8;
  localparam int unsigned PIX_W      = 8;   // coverage value
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 9;
  localparam int unsigned DIM_W      = 13;  // holds any dimension limit up to 4096
  localparam int unsigned CW         = 13;  // scaled coordinate, signed
  localparam int unsigned PW         = 9;   // pixel coordinate inside the clipped box
  localparam int unsigned DW         = 14;  // coordinate difference, signed
  localparam int unsigned PRODW      = VIN_W + DW;
  localparam int unsigned EW         = 30;  // edge function value, signed
  localparam int unsigned CNT_W      = 17;
  localparam int unsigned RD_W       = 8;   // read_x / read_y

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP   = 2'd2;

  // clipped box and edge equations handed from triangle setup to the walker
  typedef struct packed {
    logic [PW-1:0]          x0;
    logic [PW-1:0]          x1;
    logic [PW-1:0]          y0;
    logic [PW-1:0]          y1;
    logic                   empty;
    logic [2:0][EW-1:0]     e_init;
    logic [2:0][DW-1:0]     ex_step;
    logic [2:0][DW-1:0]     ey_step;
  } walk_cfg_t;

endpackage

// File: hw/rtl/tcr_store.sv
module tcr_store
  import tcr_pkg::*;
#(
  parameter int unsigned DEPTH = MAX_WIDTH_DEF * MAX_HEIGHT_DEF,
  parameter int unsigned AW    = $clog2(MAX_WIDTH_DEF * MAX_HEIGHT_DEF)
) (
  input  logic             clk_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [PIX_W-1:0] rd_data_o,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [PIX_W-1:0] wr_data_i
);

  logic [PIX_W-1:0] mem [DEPTH];
  logic [PIX_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: hw/rtl/tcr_setup.sv
module tcr_setup
  import tcr_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  go_i,
  input  logic [5:0][VIN_W-1:0] vin_i,
  input  logic [SIZE_W-1:0]     w_i,
  input  logic [SIZE_W-1:0]     h_i,
  output logic                  done_o,
  output walk_cfg_t             cfg_o
);

  localparam logic [3:0] STEP_ORIENT_A = 4'd6;
  localparam logic [3:0] STEP_ORIENT_B = 4'd7;
  localparam logic [3:0] STEP_BOX      = 4'd8;
  localparam logic [3:0] STEP_EDGE     = 4'd9;
  localparam logic [3:0] STEP_LAST     = 4'd14;

  function automatic logic signed [DW-1:0] ext_c(input logic signed [CW-1:0] a);
    return {{(DW-CW){a[CW-1]}}, a};
  endfunction

  function automatic logic signed [DW-1:0] ext_u(input logic [SIZE_W-1:0] a);
    return {{(DW-SIZE_W){1'b0}}, a};
  endfunction

  function automatic logic signed [DW-1:0] ext_p(input logic [PW-1:0] a);
    return {{(DW-PW){1'b0}}, a};
  endfunction

  function automatic logic signed [VIN_W-1:0] ext_d(input logic signed [DW-1:0] a);
    return {{(VIN_W-DW){a[DW-1]}}, a};
  endfunction

  function automatic logic signed [CW-1:0] smin(input logic signed [CW-1:0] a,
                                                input logic signed [CW-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic signed [CW-1:0] smax(input logic signed [CW-1:0] a,
                                                input logic signed [CW-1:0] b);
    return (a > b) ? a : b;
  endfunction

  logic                  active_q;
  logic                  phase_q;
  logic [3:0]            step_q;
  logic                  done_q;
  logic [5:0][VIN_W-1:0] vin_q;
  logic signed [CW-1:0]  p0x_q, p0y_q, p1x_q, p1y_q, p2x_q, p2y_q;
  logic signed [PRODW-1:0] prod_q, acc_q;
  walk_cfg_t             cfg_q;

  logic [3:0]              e_off;
  logic [1:0]              ei;
  logic                    half;
  logic signed [CW-1:0]    ax, ay, bx, by;
  logic signed [DW-1:0]    dx, dy, ox, oy, d1x, d1y, d2x, d2y;
  logic signed [VIN_W-1:0] mul_a;
  logic signed [DW-1:0]    mul_b;
  logic signed [PRODW-1:0] prod_d, rnd;
  logic signed [CW-1:0]    scaled;
  logic signed [PRODW:0]   diff;
  logic signed [CW-1:0]    xmin, xmax, ymin, ymax;
  logic signed [DW-1:0]    lo_x, hi_x, lo_y, hi_y, wm1, hm1;

  always_comb begin
    e_off = step_q - STEP_EDGE;
    ei    = e_off[2:1];
    half  = e_off[0];

    // edge i runs from vertex (i+1)%3 to vertex (i+2)%3
    unique case (ei)
      2'd0: begin
        ax = p1x_q; ay = p1y_q; bx = p2x_q; by = p2y_q;
      end
      2'd1: begin
        ax = p2x_q; ay = p2y_q; bx = p0x_q; by = p0y_q;
      end
      default: begin
        ax = p0x_q; ay = p0y_q; bx = p1x_q; by = p1y_q;
      end
    endcase

    dx  = ext_c(bx) - ext_c(ax);
    dy  = ext_c(by) - ext_c(ay);
    ox  = ext_p(cfg_q.x0) - ext_c(ax);
    oy  = ext_p(cfg_q.y0) - ext_c(ay);
    d1x = ext_c(p1x_q) - ext_c(p0x_q);
    d1y = ext_c(p1y_q) - ext_c(p0y_q);
    d2x = ext_c(p2x_q) - ext_c(p0x_q);
    d2y = ext_c(p2y_q) - ext_c(p0y_q);

    priority if (step_q < STEP_ORIENT_A) begin
      mul_a = $signed(vin_q[step_q[2:0]]);
      mul_b = step_q[0] ? ext_u(h_i) : ext_u(w_i);
    end else if (step_q == STEP_ORIENT_A) begin
      mul_a = ext_d(d1x);
      mul_b = d2y;
    end else if (step_q == STEP_ORIENT_B) begin
      mul_a = ext_d(d1y);
      mul_b = d2x;
    end else if (step_q >= STEP_EDGE) begin
      mul_a = half ? ext_d(dy) : ext_d(dx);
      mul_b = half ? ox : oy;
    end else begin
      mul_a = '0;
      mul_b = '0;
    end

    prod_d = mul_a * mul_b;

    // divide by 65536 truncating toward zero
    rnd    = prod_q + (prod_q[PRODW-1] ? $signed({{(PRODW-Q_FRAC){1'b0}}, {Q_FRAC{1'b1}}})
                                       : $signed({PRODW{1'b0}}));
    scaled = rnd[Q_FRAC +: CW];
    diff   = {acc_q[PRODW-1], acc_q} - {prod_q[PRODW-1], prod_q};

    xmin = smin(smin(p0x_q, p1x_q), p2x_q);
    xmax = smax(smax(p0x_q, p1x_q), p2x_q);
    ymin = smin(smin(p0y_q, p1y_q), p2y_q);
    ymax = smax(smax(p0y_q, p1y_q), p2y_q);
    wm1  = ext_u(w_i) - DW'(1);
    hm1  = ext_u(h_i) - DW'(1);
    lo_x = xmin[CW-1] ? '0 : ext_c(xmin);
    lo_y = ymin[CW-1] ? '0 : ext_c(ymin);
    hi_x = (ext_c(xmax) > wm1) ? wm1 : ext_c(xmax);
    hi_y = (ext_c(ymax) > hm1) ? hm1 : ext_c(ymax);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      phase_q  <= 1'b0;
      step_q   <= '0;
      done_q   <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (go_i) begin
        active_q <= 1'b1;
        phase_q  <= 1'b0;
        step_q   <= '0;
      end else if (active_q) begin
        phase_q <= ~phase_q;
        if (phase_q) begin
          if (step_q == STEP_LAST) begin
            active_q <= 1'b0;
            done_q   <= 1'b1;
          end else begin
            step_q <= step_q + 4'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      vin_q <= vin_i;
    end
    if (active_q && !phase_q) begin
      prod_q <= prod_d;
    end
    if (active_q && phase_q) begin
      acc_q <= prod_q;
      priority if (step_q < STEP_ORIENT_A) begin
        unique case (step_q[2:0])
          3'd0:    p0x_q <= scaled;
          3'd1:    p0y_q <= scaled;
          3'd2:    p1x_q <= scaled;
          3'd3:    p1y_q <= scaled;
          3'd4:    p2x_q <= scaled;
          default: p2y_q <= scaled;
        endcase
      end else if (step_q == STEP_ORIENT_B) begin
        // clockwise winding: swap second and third vertex
        if (diff[PRODW]) begin
          p1x_q <= p2x_q;
          p1y_q <= p2y_q;
          p2x_q <= p1x_q;
          p2y_q <= p1y_q;
        end
      end else if (step_q == STEP_BOX) begin
        cfg_q.x0    <= lo_x[PW-1:0];
        cfg_q.x1    <= hi_x[PW-1:0];
        cfg_q.y0    <= lo_y[PW-1:0];
        cfg_q.y1    <= hi_y[PW-1:0];
        cfg_q.empty <= (lo_x > hi_x) || (lo_y > hi_y);
      end else if (step_q >= STEP_EDGE && half) begin
        cfg_q.e_init[ei]  <= diff[EW-1:0];
        cfg_q.ex_step[ei] <= -dy;
        cfg_q.ey_step[ei] <= dx;
      end else begin
        // first product of a pair only lands in acc_q
      end
    end
  end

  assign done_o = done_q;
  assign cfg_o  = cfg_q;

endmodule

// File: hw/rtl/tcr_walk.sv
module tcr_walk
  import tcr_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF,
  parameter int unsigned AW        = $clog2(MAX_WIDTH_DEF * MAX_HEIGHT_DEF)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              go_i,
  input  walk_cfg_t         cfg_i,
  input  logic [STEP_W-1:0] step_i,
  output logic              rd_en_o,
  output logic [AW-1:0]     rd_addr_o,
  input  logic [PIX_W-1:0]  rd_data_i,
  output logic              wr_en_o,
  output logic [AW-1:0]     wr_addr_o,
  output logic [PIX_W-1:0]  wr_data_o,
  output logic              done_o,
  output logic [CNT_W-1:0]  count_o
);

  localparam logic [AW-1:0] ROW_STEP = AW'(MAX_WIDTH);

  typedef enum logic [2:0] {
    W_IDLE  = 3'b001,
    W_RUN   = 3'b010,
    W_DRAIN = 3'b100
  } walk_state_e;

  function automatic logic [EW-1:0] ext_e(input logic [DW-1:0] a);
    return {{(EW-DW){a[DW-1]}}, a};
  endfunction

  walk_state_e      state_q, state_d;
  logic [PW-1:0]    x_q, y_q;
  logic [AW-1:0]    addr_q, row_addr_q, pend_addr_q, start_addr;
  logic [EW-1:0]    e_q [3];
  logic [EW-1:0]    erow_q [3];
  logic [EW-1:0]    e_xn [3];
  logic [EW-1:0]    e_yn [3];
  logic [CNT_W-1:0] count_q;
  logic             pend_q;
  logic             hit, row_end, last;

  always_comb begin
    hit     = ~e_q[0][EW-1] & ~e_q[1][EW-1] & ~e_q[2][EW-1];
    row_end = (x_q == cfg_i.x1);
    last    = row_end && (y_q == cfg_i.y1);
    for (int i = 0; i < 3; i++) begin
      e_xn[i] = e_q[i] + ext_e(cfg_i.ex_step[i]);
      e_yn[i] = erow_q[i] + ext_e(cfg_i.ey_step[i]);
    end
    start_addr = AW'(cfg_i.y0) * ROW_STEP + AW'(cfg_i.x0);

    state_d = state_q;
    unique case (state_q)
      W_IDLE:  if (go_i) state_d = cfg_i.empty ? W_DRAIN : W_RUN;
      W_RUN:   if (last) state_d = W_DRAIN;
      W_DRAIN: state_d = W_IDLE;
      default: state_d = W_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= W_IDLE;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= (state_q == W_RUN) && hit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == W_IDLE && go_i) begin
      x_q        <= cfg_i.x0;
      y_q        <= cfg_i.y0;
      addr_q     <= start_addr;
      row_addr_q <= start_addr;
      count_q    <= '0;
      for (int i = 0; i < 3; i++) begin
        e_q[i]    <= cfg_i.e_init[i];
        erow_q[i] <= cfg_i.e_init[i];
      end
    end else if (state_q == W_RUN) begin
      pend_addr_q <= addr_q;
      if (hit && count_q != CNT_MAX) begin
        count_q <= count_q + CNT_W'(1);
      end
      if (row_end) begin
        x_q        <= cfg_i.x0;
        y_q        <= y_q + PW'(1);
        row_addr_q <= row_addr_q + ROW_STEP;
        addr_q     <= row_addr_q + ROW_STEP;
        for (int i = 0; i < 3; i++) begin
          erow_q[i] <= e_yn[i];
          e_q[i]    <= e_yn[i];
        end
      end else begin
        x_q    <= x_q + PW'(1);
        addr_q <= addr_q + AW'(1);
        for (int i = 0; i < 3; i++) begin
          e_q[i] <= e_xn[i];
        end
      end
    end
  end

  // read this pixel now, write it back next cycle; pixels of one draw never repeat
  assign rd_en_o   = (state_q == W_RUN) && hit;
  assign rd_addr_o = addr_q;
  assign wr_en_o   = pend_q;
  assign wr_addr_o = pend_addr_q;
  assign wr_data_o = rd_data_i + step_i;
  assign done_o    = (state_q == W_DRAIN);
  assign count_o   = count_q;

endmodule

// File: hw/rtl/triangle_coverage_rasterizer.sv
// triangle coverage rasterizer
//
// command channel: an item is taken at a clock edge with start high and busy
// low. command_i 0 draws the triangle v0/v1/v2 (signed Q3.16, scaled by the
// image size), command_i 1 reads the coverage byte at (read_x_i, read_y_i).
// every item returns one result word, shown for one cycle with done_o high;
// the receiver cannot hold it off, the next item may be started in that cycle.
// configuration: cfg_valid_i/cfg_ready_o with cfg_index_i (0 width, 1 height,
// 2 step) and cfg_data_i; always ready, write only while the block is idle.
// after start, a read passes through the read state and then the done register.
// a draw runs triangle setup on a single shared multiplier, then walks
// one pixel of the clipped bounding box per cycle (one read-modify-write
// of the coverage memory per cycle) and ends in the drain state.
// reset: the coverage memory is cleared one entry per cycle, and busy stays
// high until it is done.
module triangle_coverage_rasterizer
  import tcr_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic                    command_i,
  input  logic signed [VIN_W-1:0] v0_x_i,
  input  logic signed [VIN_W-1:0] v0_y_i,
  input  logic signed [VIN_W-1:0] v1_x_i,
  input  logic signed [VIN_W-1:0] v1_y_i,
  input  logic signed [VIN_W-1:0] v2_x_i,
  input  logic signed [VIN_W-1:0] v2_y_i,
  input  logic [RD_W-1:0]         read_x_i,
  input  logic [RD_W-1:0]         read_y_i,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i,
  output logic                    done_o,
  output logic [PIX_W-1:0]        read_value_o,
  output logic [CNT_W-1:0]        covered_pixels_o
);

  localparam int unsigned   DEPTH     = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned   AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
  localparam logic [AW-1:0] ROW_STEP  = AW'(MAX_WIDTH);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_READ  = 4'b0100,
    ST_DRAW  = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  logic [AW-1:0]     clr_q;
  logic [SIZE_W-1:0] width_q, height_q, w_eff, h_eff;
  logic [STEP_W-1:0] step_q;
  logic              in_range, in_range_q;
  logic              accept;
  logic              done_q;
  logic [PIX_W-1:0]  read_value_q;
  logic [CNT_W-1:0]  covered_q;

  logic              mem_rd_en, mem_wr_en;
  logic [AW-1:0]     mem_rd_addr, mem_wr_addr, read_addr;
  logic [PIX_W-1:0]  mem_rd_data, mem_wr_data;

  logic                  setup_done;
  walk_cfg_t             walk_cfg;
  logic                  walk_rd_en, walk_wr_en, walk_done;
  logic [AW-1:0]         walk_rd_addr, walk_wr_addr;
  logic [PIX_W-1:0]      walk_wr_data;
  logic [CNT_W-1:0]      walk_count;
  logic [5:0][VIN_W-1:0] vin;

  assign accept      = start && !busy;
  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign vin         = {v2_y_i, v2_x_i, v1_y_i, v1_x_i, v0_y_i, v0_x_i};

  // sizes above the store saturate for scaling and clipping alike
  assign w_eff = ({{(DIM_W-SIZE_W){1'b0}}, width_q} > DIM_W'(MAX_WIDTH))
               ? SIZE_W'(MAX_WIDTH) : width_q;
  assign h_eff = ({{(DIM_W-SIZE_W){1'b0}}, height_q} > DIM_W'(MAX_HEIGHT))
               ? SIZE_W'(MAX_HEIGHT) : height_q;

  assign in_range  = ({{(DIM_W-RD_W){1'b0}}, read_x_i} < DIM_W'(MAX_WIDTH))
                  && ({{(DIM_W-RD_W){1'b0}}, read_y_i} < DIM_W'(MAX_HEIGHT));
  assign read_addr = AW'(read_y_i) * ROW_STEP + AW'(read_x_i);

  always_comb begin
    state_d     = state_q;
    mem_rd_en   = 1'b0;
    mem_rd_addr = read_addr;
    mem_wr_en   = 1'b0;
    mem_wr_addr = clr_q;
    mem_wr_data = '0;
    unique case (state_q)
      ST_CLEAR: begin
        mem_wr_en = 1'b1;
        if (clr_q == LAST_ADDR) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        mem_rd_en = accept && command_i;
        if (accept) state_d = command_i ? ST_READ : ST_DRAW;
      end
      ST_READ: begin
        state_d = ST_IDLE;
      end
      ST_DRAW: begin
        mem_rd_en   = walk_rd_en;
        mem_rd_addr = walk_rd_addr;
        mem_wr_en   = walk_wr_en;
        mem_wr_addr = walk_wr_addr;
        mem_wr_data = walk_wr_data;
        if (walk_done) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      clr_q    <= '0;
      width_q  <= SIZE_W'(256);
      height_q <= SIZE_W'(256);
      step_q   <= STEP_W'(1);
      done_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= ((state_q == ST_READ) || (state_q == ST_DRAW && walk_done));
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + AW'(1);
      end
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          REG_WIDTH:  width_q  <= cfg_data_i[SIZE_W-1:0];
          REG_HEIGHT: height_q <= cfg_data_i[SIZE_W-1:0];
          REG_STEP:   step_q   <= cfg_data_i[STEP_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_range_q <= in_range;
    end
    if (state_q == ST_READ) begin
      read_value_q <= in_range_q ? mem_rd_data : '0;
      covered_q    <= '0;
    end else if (state_q == ST_DRAW && walk_done) begin
      read_value_q <= '0;
      covered_q    <= walk_count;
    end
  end

  assign done_o           = done_q;
  assign read_value_o     = read_value_q;
  assign covered_pixels_o = covered_q;

  tcr_setup u_setup (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (accept && !command_i),
    .vin_i  (vin),
    .w_i    (w_eff),
    .h_i    (h_eff),
    .done_o (setup_done),
    .cfg_o  (walk_cfg)
  );

  tcr_walk #(
    .MAX_WIDTH (MAX_WIDTH),
    .AW        (AW)
  ) u_walk (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .go_i      (setup_done),
    .cfg_i     (walk_cfg),
    .step_i    (step_q),
    .rd_en_o   (walk_rd_en),
    .rd_addr_o (walk_rd_addr),
    .rd_data_i (mem_rd_data),
    .wr_en_o   (walk_wr_en),
    .wr_addr_o (walk_wr_addr),
    .wr_data_o (walk_wr_data),
    .done_o    (walk_done),
    .count_o   (walk_count)
  );

  tcr_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i     (clk_i),
    .rd_en_i   (mem_rd_en),
    .rd_addr_i (mem_rd_addr),
    .rd_data_o (mem_rd_data),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (mem_wr_addr),
    .wr_data_i (mem_wr_data)
  );

endmodule

// File: hw/rtl/tcr_checker.sv
module tcr_checker
  import tcr_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start,
  input logic             busy,
  input logic             command_i,
  input logic             done_o,
  input logic [PIX_W-1:0] read_value_o,
  input logic [CNT_W-1:0] covered_pixels_o
);

  // a read answers after passing through the read state and the done register
  a_read_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && command_i) |-> ##2 done_o)
    else $error("read result not returned two cycles after start");

  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after an accepted item");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while still busy");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result word repeated");

  a_one_field_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (read_value_o == '0 || covered_pixels_o == '0))
    else $error("read value and pixel count both nonzero");

endmodule

bind triangle_coverage_rasterizer tcr_checker u_tcr_checker (.*);

// File: dv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tcr_pkg::*;

  localparam logic CMD_DRAW = 1'b0;
  localparam logic CMD_READ = 1'b1;
  localparam int   IMG_WORDS = MAX_WIDTH_DEF * MAX_HEIGHT_DEF;
  localparam int   Q_MIN = -(1 << (VIN_W - 1));
  localparam int   Q_MAX = (1 << (VIN_W - 1)) - 1;

  typedef struct packed {
    logic             command;
    logic [VIN_W-1:0] ax;
    logic [VIN_W-1:0] ay;
    logic [VIN_W-1:0] bx;
    logic [VIN_W-1:0] by;
    logic [VIN_W-1:0] cx;
    logic [VIN_W-1:0] cy;
    logic [RD_W-1:0]  rx;
    logic [RD_W-1:0]  ry;
  } raster_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] value;
    logic [CNT_W-1:0] count;
  } coverage_word_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic                  command_i = CMD_DRAW;
  logic [VIN_W-1:0]      v0_x_i = '0;
  logic [VIN_W-1:0]      v0_y_i = '0;
  logic [VIN_W-1:0]      v1_x_i = '0;
  logic [VIN_W-1:0]      v1_y_i = '0;
  logic [VIN_W-1:0]      v2_x_i = '0;
  logic [VIN_W-1:0]      v2_y_i = '0;
  logic [RD_W-1:0]       read_x_i = '0;
  logic [RD_W-1:0]       read_y_i = '0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = REG_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  done_o;
  logic [PIX_W-1:0]      read_value_o;
  logic [CNT_W-1:0]      covered_pixels_o;

  // shadow of the coverage store and the registers
  logic [PIX_W-1:0]  shadow_image [IMG_WORDS];
  logic [SIZE_W-1:0] cur_width = 9'd256;
  logic [SIZE_W-1:0] cur_height = 9'd256;
  logic [STEP_W-1:0] cur_step = 8'd1;

  coverage_word_t pending_words [$];
  int             mismatches = 0;
  bit             gaps_on = 1'b1;
  int             last_x = 0;
  int             last_y = 0;
  int             wide_left = 3;
  int             mid_left = 6;

  triangle_coverage_rasterizer i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .command_i        (command_i),
    .v0_x_i           (v0_x_i),
    .v0_y_i           (v0_y_i),
    .v1_x_i           (v1_x_i),
    .v1_y_i           (v1_y_i),
    .v2_x_i           (v2_x_i),
    .v2_y_i           (v2_y_i),
    .read_x_i         (read_x_i),
    .read_y_i         (read_y_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .done_o           (done_o),
    .read_value_o     (read_value_o),
    .covered_pixels_o (covered_pixels_o)
  );

  always #10 clk_i = ~clk_i;

  initial begin
    #1000ms;
    $display("tb: errors");
    $finish;
  end

  // ---------------------------------------------------------------- prediction

  function automatic longint scaled(input logic [VIN_W-1:0] q, input longint size);
    return (longint'($signed(q)) * size) / (longint'(1) << Q_FRAC);
  endfunction

  function automatic longint edge_at(input longint ax, input longint ay, input longint bx,
                                     input longint by, input longint x, input longint y);
    return (bx - ax) * (y - ay) - (by - ay) * (x - ax);
  endfunction

  function automatic coverage_word_t predict_word(input raster_item_t it);
    coverage_word_t word;
    longint w, h, x0, y0, x1, y1, t;
    longint px0, py0, px1, py1, px2, py2;
    int unsigned hits;
    word = '0;
    if (it.command == CMD_READ) begin
      if (it.rx < MAX_WIDTH_DEF && it.ry < MAX_HEIGHT_DEF)
        word.value = shadow_image[int'(it.ry) * MAX_WIDTH_DEF + int'(it.rx)];
      return word;
    end
    w = (cur_width > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : cur_width;
    h = (cur_height > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : cur_height;
    px0 = scaled(it.ax, w);
    py0 = scaled(it.ay, h);
    px1 = scaled(it.bx, w);
    py1 = scaled(it.by, h);
    px2 = scaled(it.cx, w);
    py2 = scaled(it.cy, h);
    // clockwise: swap second and third vertex
    if (edge_at(px0, py0, px1, py1, px2, py2) < 0) begin
      t = px1; px1 = px2; px2 = t;
      t = py1; py1 = py2; py2 = t;
    end
    x0 = px0; if (px1 < x0) x0 = px1; if (px2 < x0) x0 = px2;
    y0 = py0; if (py1 < y0) y0 = py1; if (py2 < y0) y0 = py2;
    x1 = px0; if (px1 > x1) x1 = px1; if (px2 > x1) x1 = px2;
    y1 = py0; if (py1 > y1) y1 = py1; if (py2 > y1) y1 = py2;
    if (x0 < 0) x0 = 0;
    if (y0 < 0) y0 = 0;
    if (x1 > w - 1) x1 = w - 1;
    if (y1 > h - 1) y1 = h - 1;
    hits = 0;
    for (longint y = y0; y <= y1; y++) begin
      for (longint x = x0; x <= x1; x++) begin
        if (edge_at(px1, py1, px2, py2, x, y) >= 0 && edge_at(px2, py2, px0, py0, x, y) >= 0 &&
            edge_at(px0, py0, px1, py1, x, y) >= 0) begin
          shadow_image[int'(y) * MAX_WIDTH_DEF + int'(x)] =
            shadow_image[int'(y) * MAX_WIDTH_DEF + int'(x)] + cur_step;
          if (hits < CNT_MAX) hits++;
        end
      end
    end
    word.count = hits[CNT_W-1:0];
    return word;
  endfunction

  // ---------------------------------------------------------------- result check

  always @(posedge clk_i) begin
    coverage_word_t want;
    if (done_o === 1'b1) begin
      if (pending_words.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected word: read_value %0d covered_pixels %0d",
                   read_value_o, covered_pixels_o);
        mismatches++;
      end else begin
        want = pending_words.pop_front();
        if (read_value_o !== want.value || covered_pixels_o !== want.count) begin
          if (mismatches < 10)
            $display("mismatch: read_value exp %0d got %0d, covered_pixels exp %0d got %0d",
                     want.value, read_value_o, want.count, covered_pixels_o);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- item builders

  function automatic int eff_size(input logic [SIZE_W-1:0] r);
    if (r == 0) return 1;
    return (r > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(r);
  endfunction

  // pixel coordinate to Q3.16 with a random fraction, clamped to the field range
  function automatic int to_q(input int p, input int size);
    int q;
    q = p * 65536 / size + int'($urandom_range(0, 65535 / size));
    if (q < Q_MIN) q = Q_MIN;
    if (q > Q_MAX) q = Q_MAX;
    return q;
  endfunction

  function automatic raster_item_t draw_q(input int ax, input int ay, input int bx,
                                          input int by, input int cx, input int cy);
    raster_item_t it;
    it.command = CMD_DRAW;
    it.ax = ax[VIN_W-1:0];
    it.ay = ay[VIN_W-1:0];
    it.bx = bx[VIN_W-1:0];
    it.by = by[VIN_W-1:0];
    it.cx = cx[VIN_W-1:0];
    it.cy = cy[VIN_W-1:0];
    it.rx = RD_W'($urandom);
    it.ry = RD_W'($urandom);
    return it;
  endfunction

  function automatic raster_item_t draw_px(input int ax, input int ay, input int bx,
                                           input int by, input int cx, input int cy);
    int w, h;
    w = eff_size(cur_width);
    h = eff_size(cur_height);
    return draw_q(to_q(ax, w), to_q(ay, h), to_q(bx, w), to_q(by, h), to_q(cx, w),
                  to_q(cy, h));
  endfunction

  function automatic raster_item_t read_px(input int x, input int y);
    raster_item_t it;
    it = draw_q($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    it.command = CMD_READ;
    it.rx = x[RD_W-1:0];
    it.ry = y[RD_W-1:0];
    return it;
  endfunction

  function automatic int near(input int v);
    int r;
    r = v + int'($urandom_range(0, 6)) - 3;
    if (r < 0) r = 0;
    if (r > 255) r = 255;
    return r;
  endfunction

  function automatic int jitter(input int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // mostly small triangles near the image, some mid-sized and a few wide ones, reads mostly around the last one
  function automatic raster_item_t next_random_item();
    int pick, span;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      if ($urandom_range(0, 2) != 0) return read_px(near(last_x), near(last_y));
      return read_px($urandom_range(0, 255), $urandom_range(0, 255));
    end
    if (pick < 32 && wide_left > 0) begin
      wide_left--;
      return draw_q($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end
    span = 12;
    if (pick < 40 && mid_left > 0) begin
      mid_left--;
      span = 80;
    end
    last_x = int'($urandom_range(0, eff_size(cur_width) + 7)) - 4;
    last_y = int'($urandom_range(0, eff_size(cur_height) + 7)) - 4;
    return draw_px(last_x + jitter(span), last_y + jitter(span), last_x + jitter(span),
                   last_y + jitter(span), last_x + jitter(span), last_y + jitter(span));
  endfunction

  // ---------------------------------------------------------------- drivers

  task automatic send_item(input raster_item_t it);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    start     <= 1'b1;
    command_i <= it.command;
    v0_x_i    <= it.ax;
    v0_y_i    <= it.ay;
    v1_x_i    <= it.bx;
    v1_y_i    <= it.by;
    v2_x_i    <= it.cx;
    v2_y_i    <= it.cy;
    read_x_i  <= it.rx;
    read_y_i  <= it.ry;
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
    pending_words.push_back(predict_word(it));
  endtask

  // hold off until every word is back
  task automatic quiesce();
    start <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h,
                            input logic [STEP_W-1:0] s);
    logic [CFG_IDX_W-1:0]  regs [3];
    logic [CFG_DATA_W-1:0] vals [3];
    regs[0] = REG_WIDTH;
    regs[1] = REG_HEIGHT;
    regs[2] = REG_STEP;
    vals[0] = w;
    vals[1] = h;
    vals[2] = {{(CFG_DATA_W-STEP_W){1'b0}}, s};
    quiesce();
    cfg_valid_i <= 1'b1;
    for (int k = 0; k < 3; k++) begin
      cfg_index_i <= regs[k];
      cfg_data_i  <= vals[k];
      @(posedge clk_i);
      while (cfg_ready_o !== 1'b1) @(posedge clk_i);
      case (regs[k])
        REG_WIDTH:  cur_width = vals[k];
        REG_HEIGHT: cur_height = vals[k];
        REG_STEP:   cur_step = vals[k][STEP_W-1:0];
        default: ;
      endcase
    end
    cfg_valid_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_reset_state();
    send_item(read_px(0, 0));
    send_item(read_px(255, 255));
    send_item(read_px(37, 200));
  endtask

  task automatic test_shapes();
    send_item(draw_px(10, 10, 30, 10, 10, 30));
    send_item(draw_px(40, 40, 40, 60, 60, 40));       // clockwise
    send_item(draw_px(5, 100, 25, 100, 45, 100));     // zero area
    send_item(draw_px(200, 200, 200, 200, 200, 200)); // single point
    send_item(draw_px(-20, -20, -5, -30, -10, -2));   // box off the image
    send_item(draw_q(Q_MIN, Q_MIN, Q_MAX, Q_MIN, Q_MIN, Q_MAX));
    send_item(draw_q(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX));
    send_item(read_px(15, 15));
    send_item(read_px(50, 45));
    send_item(read_px(25, 100));
    send_item(read_px(200, 200));
    send_item(read_px(255, 0));
  endtask

  task automatic test_config_extremes();
    set_config(9'd0, 9'd256, 8'd1);
    send_item(draw_q(0, 0, Q_MAX, 0, 0, Q_MAX));
    // oversized width saturates, one row, step wraps
    set_config(9'd511, 9'd1, 8'd255);
    send_item(draw_q(0, 0, Q_MAX, 0, 0, Q_MAX));
    send_item(draw_q(0, 0, Q_MAX, 0, 0, Q_MAX));
    send_item(read_px(10, 0));
    set_config(9'd1, 9'd1, 8'd0);
    send_item(draw_q(0, 0, 65535, 0, 0, 65535));
    send_item(read_px(0, 0));
    set_config(9'd256, 9'd0, 8'd7);
    send_item(draw_q(0, 0, Q_MAX, 0, 0, Q_MAX));
  endtask

  function automatic logic [SIZE_W-1:0] pick_size();
    case ($urandom_range(0, 9))
      0: return 9'd1;
      1: return 9'd511;
      2: return 9'd256;
      3: return ($urandom_range(0, 3) == 0) ? 9'd0 : 9'd256;
      default: return SIZE_W'($urandom_range(1, 511));
    endcase
  endfunction

  task automatic test_random_phases();
    for (int ph = 0; ph < 5; ph++) begin
      set_config(pick_size(), pick_size(), STEP_W'($urandom_range(0, 255)));
      repeat (14) send_item(next_random_item());
    end
  endtask

  task automatic test_back_to_back();
    set_config(9'd256, 9'd256, STEP_W'($urandom_range(0, 255)));
    gaps_on = 1'b0;
    repeat (12) send_item(next_random_item());
  endtask

  initial begin
    for (int i = 0; i < IMG_WORDS; i++) shadow_image[i] = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_state();
    test_shapes();
    test_config_extremes();
    test_random_phases();
    test_back_to_back();
    quiesce();
    repeat (40) @(posedge clk_i);
    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/tcr_pkg.sv
hw/rtl/tcr_store.sv
hw/rtl/tcr_setup.sv
hw/rtl/tcr_walk.sv
hw/rtl/triangle_coverage_rasterizer.sv
hw/rtl/tcr_checker.sv
dv/tb.sv
